[hdl/assert_macros.svh]
// Assertion macros shared by the cross blur RTL.
// Clocked on clk; the reset-qualified forms are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PPCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PPCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ppcb_pkg.sv]
// Package for the packed pixel cross blur: request structs, mask struct,
// register indexes and default geometry. No dependencies.
`default_nettype none

package ppcb_pkg;

    localparam int DEF_WORDS_PER_ROW = 80;
    localparam int DEF_ROWS          = 200;

    localparam int WORD_W      = 32;
    localparam int PIXEL_W     = 8;
    localparam int PIXELS      = WORD_W / PIXEL_W;
    localparam int ROW_FIELD_W = 12;
    localparam int COL_FIELD_W = 10;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_AFTER_SHIFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_LOW_BIT    = 1'b1;

    localparam logic [PIXEL_W-1:0] KEEP_RESET = 8'd109;
    localparam logic [PIXEL_W-1:0] LOW_RESET  = 8'd37;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_word;
        logic              first_of_frame;
    } ppcb_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]      blurred_word;
        logic [ROW_FIELD_W-1:0] out_row;
        logic [COL_FIELD_W-1:0] out_column;
        logic                   last_of_frame;
    } ppcb_out_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] keep;
        logic [PIXEL_W-1:0] low;
    } ppcb_mask_t;

endpackage

`default_nettype wire

[hdl/ppcb_ram.sv]
// Generic simple RAM: one write port, two registered read ports, read-old
// on a same-address write. No dependencies.
`default_nettype none

module ppcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

[hdl/ppcb_avg.sv]
// Packed four-pixel masked average (a floor average when keep is 8'h7F and low is 8'h01), one averaging lane.
// Depends on ppcb_pkg for the mask struct.
`default_nettype none

module ppcb_avg (
    input  wire logic [ppcb_pkg::WORD_W-1:0] a,
    input  wire logic [ppcb_pkg::WORD_W-1:0] b,
    input  wire ppcb_pkg::ppcb_mask_t        mask,
    output logic      [ppcb_pkg::WORD_W-1:0] avg
);
    import ppcb_pkg::*;

    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] low;

    assign keep = {PIXELS{mask.keep}};
    assign low  = {PIXELS{mask.low}};
    assign avg  = ((a >> 1) & keep) + ((b >> 1) & keep) + (a & b & low);

endmodule

`default_nettype wire

[hdl/ppcb_merge.sv]
// Merge stage: folds the vertical and horizontal lane results and the
// center word into the blurred word. Depends on ppcb_pkg and ppcb_avg.
`default_nettype none

module ppcb_merge (
    input  wire logic [ppcb_pkg::WORD_W-1:0] vert,
    input  wire logic [ppcb_pkg::WORD_W-1:0] horiz,
    input  wire logic [ppcb_pkg::WORD_W-1:0] center,
    input  wire ppcb_pkg::ppcb_mask_t        mask,
    output logic      [ppcb_pkg::WORD_W-1:0] blurred
);
    import ppcb_pkg::*;

    logic [WORD_W-1:0] cross_avg;

    ppcb_avg u_cross (
        .a    (vert),
        .b    (horiz),
        .mask (mask),
        .avg  (cross_avg)
    );

    ppcb_avg u_final (
        .a    (cross_avg),
        .b    (center),
        .mask (mask),
        .avg  (blurred)
    );

endmodule

`default_nettype wire

[hdl/packed_pixel_cross_blur.sv]
// Top level of the packed pixel cross blur: position counters, line store,
// two averaging lanes, merge stage and output register.
// Depends on ppcb_pkg, ppcb_ram, ppcb_avg, ppcb_merge, assert_macros.svh.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall     ppcb_in_t  in_data
//   out       output     out_valid / out_stall   ppcb_out_t out_data
//   cfg       input      cfg_write               cfg_index, cfg_data
//
// One request accepted per clock while in_stall is low; a result is registered in
// the lane stage and then in the output register.
// The line store RAM is read ahead from the next position (up word from two rows
// above, next word of the row above), with a bypass for a same-cycle write.
// Reset clears counters and loads the reset masks; the line store is not cleared.
// in_stall is high only while the lane stage and output register both hold
// a result and out_stall is high.
`default_nettype none
`include "assert_macros.svh"

module packed_pixel_cross_blur #(
    parameter int WORDS_PER_ROW = ppcb_pkg::DEF_WORDS_PER_ROW,
    parameter int ROWS          = ppcb_pkg::DEF_ROWS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire ppcb_pkg::ppcb_in_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output ppcb_pkg::ppcb_out_t                     out_data,
    input  wire logic                               cfg_write,
    input  wire logic [ppcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ppcb_pkg::PIXEL_W-1:0]       cfg_data
);
    import ppcb_pkg::*;

    localparam int COL_W  = $clog2(WORDS_PER_ROW);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int DEPTH  = 2 * WORDS_PER_ROW;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(WORDS_PER_ROW - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0]  FIRST_OUT_ROW = ROW_W'(2);
    localparam logic [ADDR_W-1:0] BANK_OFS = ADDR_W'(WORDS_PER_ROW);

    typedef struct packed {
        logic [WORD_W-1:0]      vert;
        logic [WORD_W-1:0]      horiz;
        logic [WORD_W-1:0]      center;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic                   last;
    } ppcb_s1_t;

    ppcb_mask_t        mask_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              bank_reg, bank_next;
    logic [WORD_W-1:0] left_reg, left_next;
    logic [WORD_W-1:0] row_start_reg, row_start_next;
    logic [WORD_W-1:0] prev_start_reg, prev_start_next;
    logic [WORD_W-1:0] center_reg, center_next;
    logic              byp_a_reg, byp_b_reg;
    logic [WORD_W-1:0] byp_data_reg;
    logic              s1_valid_reg;
    ppcb_s1_t          s1_reg, s1_next;
    logic              out_valid_reg;
    ppcb_out_t         out_data_reg;

    logic              accept, out_load;
    logic              fr, bank_eff, emit;
    logic [ROW_W-1:0]  r_eff;
    logic [COL_W-1:0]  c_eff, c_rd_b;
    logic [WORD_W-1:0] left_eff, row_start_eff, up_w, next_mem, center_w, next_w;
    logic [WORD_W-1:0] left_n, right_n, vert_w, horiz_w, blurred_w;
    logic [WORD_W-1:0] rd_a, rd_b;
    logic [ADDR_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
    logic              last_out, last_pos_ok;

    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        fr            = in_data.first_of_frame;
        r_eff         = fr ? '0 : row_reg;
        c_eff         = fr ? '0 : col_reg;
        bank_eff      = fr ? 1'b0 : bank_reg;
        left_eff      = fr ? '0 : left_reg;
        row_start_eff = (c_eff == '0) ? in_data.pixel_word : row_start_reg;
        up_w          = byp_a_reg ? byp_data_reg : rd_a;
        next_mem      = byp_b_reg ? byp_data_reg : rd_b;
        center_w      = (c_eff == '0) ? prev_start_reg : center_reg;
        next_w        = (c_eff == LAST_COL) ? row_start_eff : next_mem;
        emit          = (r_eff >= FIRST_OUT_ROW);
        left_n        = {center_w[WORD_W-PIXEL_W-1:0], left_eff[WORD_W-1 -: PIXEL_W]};
        right_n       = {next_w[PIXEL_W-1:0], center_w[WORD_W-1:PIXEL_W]};
        wr_addr       = bank_eff ? BANK_OFS + ADDR_W'(c_eff) : ADDR_W'(c_eff);

        row_next        = row_reg;
        col_next        = col_reg;
        bank_next       = bank_reg;
        left_next       = left_reg;
        row_start_next  = row_start_reg;
        prev_start_next = prev_start_reg;
        center_next     = center_reg;
        if (accept)
        begin
            row_start_next = row_start_eff;
            center_next    = next_w;
            left_next      = emit ? center_w : left_eff;
            if (c_eff == LAST_COL)
            begin
                col_next        = '0;
                prev_start_next = row_start_eff;
                if (r_eff == LAST_ROW)
                begin
                    row_next  = '0;
                    bank_next = 1'b0;
                    left_next = '0;
                end
                else
                begin
                    row_next  = ROW_W'(r_eff + 1'b1);
                    bank_next = !bank_eff;
                end
            end
            else
            begin
                col_next  = COL_W'(c_eff + 1'b1);
                row_next  = r_eff;
                bank_next = bank_eff;
            end
        end

        c_rd_b    = (col_next == LAST_COL) ? col_next : COL_W'(col_next + 1'b1);
        rd_a_addr = bank_next ? BANK_OFS + ADDR_W'(col_next) : ADDR_W'(col_next);
        rd_b_addr = bank_next ? ADDR_W'(c_rd_b) : BANK_OFS + ADDR_W'(c_rd_b);

        s1_next.vert   = vert_w;
        s1_next.horiz  = horiz_w;
        s1_next.center = center_w;
        s1_next.row    = ROW_FIELD_W'(ROW_W'(r_eff - 1'b1));
        s1_next.col    = COL_FIELD_W'(c_eff);
        s1_next.last   = (r_eff == LAST_ROW) && (c_eff == LAST_COL);
    end

    ppcb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk     (clk),
        .we      (accept),
        .waddr   (wr_addr),
        .wdata   (in_data.pixel_word),
        .raddr_a (rd_a_addr),
        .rdata_a (rd_a),
        .raddr_b (rd_b_addr),
        .rdata_b (rd_b)
    );

    ppcb_avg u_lane_vert (
        .a    (up_w),
        .b    (in_data.pixel_word),
        .mask (mask_reg),
        .avg  (vert_w)
    );

    ppcb_avg u_lane_horiz (
        .a    (left_n),
        .b    (right_n),
        .mask (mask_reg),
        .avg  (horiz_w)
    );

    ppcb_merge u_merge (
        .vert    (s1_reg.vert),
        .horiz   (s1_reg.horiz),
        .center  (s1_reg.center),
        .mask    (mask_reg),
        .blurred (blurred_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg.keep <= KEEP_RESET;
            mask_reg.low  <= LOW_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            bank_reg      <= 1'b0;
            left_reg      <= '0;
            byp_a_reg     <= 1'b0;
            byp_b_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KEEP_AFTER_SHIFT: mask_reg.keep <= cfg_data;
                    REG_FIELD_LOW_BIT:    mask_reg.low  <= cfg_data;
                endcase
            end
            row_reg   <= row_next;
            col_reg   <= col_next;
            bank_reg  <= bank_next;
            left_reg  <= left_next;
            byp_a_reg <= accept && (wr_addr == rd_a_addr);
            byp_b_reg <= accept && (wr_addr == rd_b_addr);
            if (accept)
            begin
                s1_valid_reg <= emit;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_start_reg  <= row_start_next;
        prev_start_reg <= prev_start_next;
        center_reg     <= center_next;
        byp_data_reg   <= in_data.pixel_word;
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (out_load && s1_valid_reg)
        begin
            out_data_reg.blurred_word  <= blurred_w;
            out_data_reg.out_row       <= s1_reg.row;
            out_data_reg.out_column    <= s1_reg.col;
            out_data_reg.last_of_frame <= s1_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign last_out    = out_valid_reg && out_data_reg.last_of_frame;
    assign last_pos_ok = (out_data_reg.out_column == COL_FIELD_W'(WORDS_PER_ROW - 1)) &&
                         (out_data_reg.out_row == ROW_FIELD_W'(ROWS - 2));

    `PPCB_ASSERT(a_col_range, col_reg <= LAST_COL, "column counter past row end")
    `PPCB_ASSERT_NEXT(a_stage_load, accept, s1_valid_reg == $past(emit), "lane stage load")
    `PPCB_ASSERT(a_stall_cause, !in_stall || (s1_valid_reg && out_valid_reg), "stall w/o full pipe")
    `PPCB_ASSERT(a_last_pos, !last_out || last_pos_ok, "last_of_frame position")

endmodule

`default_nettype wire

[dv/tb_packed_pixel_cross_blur.sv]
// Self-checking testbench for packed_pixel_cross_blur: drives pixel word requests,
// predicts each blurred word, and checks the result stream. Configures the masks.
// Depends on ppcb_pkg and the packed_pixel_cross_blur RTL.
module tb_packed_pixel_cross_blur;
    timeunit 1ns;
    timeprecision 1ps;

    import ppcb_pkg::*;

    localparam int WPR          = DEF_WORDS_PER_ROW;
    localparam int FRAME_ROWS   = DEF_ROWS;
    localparam int RANDOM_ITEMS = 400;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    ppcb_in_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    ppcb_out_t            out_data;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PIXEL_W-1:0]   cfg_data;

    // predictor state
    logic [WORD_W-1:0]  line_copy [2*WPR];
    logic [WORD_W-1:0]  prev_center;
    logic [WORD_W-1:0]  row_head;
    int                 pos_row;
    int                 pos_col;
    bit                 pos_bank;
    logic [PIXEL_W-1:0] keep_mask;
    logic [PIXEL_W-1:0] low_mask;
    ppcb_out_t          blur_expect_q [$];

    int error_count  = 0;
    int hold_request = 0;
    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;

    packed_pixel_cross_blur uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] pixel_avg(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] l;
        k = {PIXELS{keep_mask}};
        l = {PIXELS{low_mask}};
        return ((a >> 1) & k) + ((b >> 1) & k) + (a & b & l);
    endfunction

    function automatic void restart_position();
        pos_row     = 0;
        pos_col     = 0;
        pos_bank    = 1'b0;
        prev_center = '0;
    endfunction

    function automatic void predict_blur(logic [WORD_W-1:0] word, logic first);
        int                r;
        int                c;
        int                cur_base;
        int                prev_base;
        logic [WORD_W-1:0] up;
        logic [WORD_W-1:0] center;
        logic [WORD_W-1:0] nxt;
        logic [WORD_W-1:0] lft;
        logic [WORD_W-1:0] rgt;
        ppcb_out_t         res;
        if (first)
            restart_position();
        r         = pos_row;
        c         = pos_col;
        cur_base  = pos_bank ? WPR : 0;
        prev_base = pos_bank ? 0 : WPR;
        if (c == 0)
            row_head = word;
        if (r >= 2)
        begin
            up     = line_copy[cur_base + c];
            center = line_copy[prev_base + c];
            nxt    = (c + 1 < WPR) ? line_copy[prev_base + c + 1] : row_head;
            lft    = {center[23:0], prev_center[31:24]};
            rgt    = {nxt[7:0], center[31:8]};
            res.blurred_word  = pixel_avg(pixel_avg(pixel_avg(up, word), pixel_avg(lft, rgt)),
                                          center);
            res.out_row       = ROW_FIELD_W'(r - 1);
            res.out_column    = COL_FIELD_W'(c);
            res.last_of_frame = (r == FRAME_ROWS - 1) && (c == WPR - 1);
            blur_expect_q.push_back(res);
            prev_center = center;
        end
        line_copy[cur_base + c] = word;
        c++;
        if (c >= WPR)
        begin
            c        = 0;
            pos_bank = !pos_bank;
            r++;
        end
        pos_col = c;
        pos_row = r;
        if (r >= FRAME_ROWS)
            restart_position();
    endfunction

    function automatic logic [WORD_W-1:0] random_pixel_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // One request; returns at the edge where it is accepted.
    task automatic send_req(input logic [WORD_W-1:0] word, input logic first);
        if (tx_idle_en && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{pixel_word: word, first_of_frame: first};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_blur(word, first);
    endtask

    task automatic send_run(input int count, input logic start_frame);
        int i;
        for (i = 0; i < count; i++)
            send_req(random_pixel_word(), start_frame && i == 0);
    endtask

    // Rows 0 and 1 produce nothing, so wait out the pipeline after the queue empties.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (blur_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input logic [CFG_IDX_W-1:0] idx, input logic [PIXEL_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_KEEP_AFTER_SHIFT)
            keep_mask = val;
        else
            low_mask = val;
        @(posedge clk);
    endtask

    task automatic set_masks(input logic [PIXEL_W-1:0] keep, input logic [PIXEL_W-1:0] low);
        drain_results();
        write_mask(REG_KEEP_AFTER_SHIFT, keep);
        write_mask(REG_FIELD_LOW_BIT, low);
    endtask

    task automatic test_directed_patterns();
        logic [WORD_W-1:0] pats [12];
        int                i;
        pats[0]  = 32'h0000_0000;
        pats[1]  = 32'hFFFF_FFFF;
        pats[2]  = 32'h0000_0001;
        pats[3]  = 32'h8000_0000;
        pats[4]  = 32'h0000_00FF;
        pats[5]  = 32'hFF00_0000;
        pats[6]  = 32'hAAAA_AAAA;
        pats[7]  = 32'h5555_5555;
        pats[8]  = 32'h7F7F_7F7F;
        pats[9]  = 32'h8080_8080;
        pats[10] = 32'h0101_0101;
        pats[11] = 32'hFEFE_FEFE;
        for (i = 0; i < 3 * WPR; i++)
            send_req(pats[(i + 5 * (i / WPR)) % 12], i == 0);
        drain_results();
    endtask

    // Continues the frame left at row 3 by the directed patterns.
    task automatic test_mask_settings();
        int i;
        for (i = 0; i < 6; i++)
        begin
            case (i)
                0:       set_masks(8'h00, 8'h00);
                1:       set_masks(8'hFF, 8'hFF);
                2:       set_masks(8'h00, 8'hFF);
                3:       set_masks(8'hFF, 8'h00);
                4:       set_masks(PIXEL_W'($urandom()), PIXEL_W'($urandom()));
                default: set_masks(KEEP_RESET, LOW_RESET);
            endcase
            send_run(10, 1'b0);
        end
        drain_results();
    endtask

    task automatic test_early_restart();
        send_run(5, 1'b1);
        send_run(1, 1'b1);
        send_run(2 * WPR + 10, 1'b1);
        drain_results();
    endtask

    // Continues the output rows left by the early restart test.
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_request = 120;
        send_run(60, 1'b0);
        drain_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_run(20, 1'b0);
        drain_results();
    endtask

    task automatic test_random_frames();
        int   sent;
        int   frame_len;
        int   i;
        logic first;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent > RANDOM_ITEMS - 150)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            else
            begin
                tx_idle_en = $urandom_range(0, 3) != 0;
                rx_idle_en = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 3) == 0)
                set_masks(PIXEL_W'($urandom()), PIXEL_W'($urandom()));
            if ($urandom_range(0, 4) == 0)
                frame_len = $urandom_range(1, 2 * WPR);
            else
                frame_len = $urandom_range(2 * WPR + 1, 3 * WPR);
            if (frame_len > RANDOM_ITEMS - sent)
                frame_len = RANDOM_ITEMS - sent;
            for (i = 0; i < frame_len; i++)
            begin
                if (i == 0)
                    first = $urandom_range(0, 9) != 0;
                else
                    first = $urandom_range(0, 199) == 0;
                send_req(random_pixel_word(), first);
            end
            sent += frame_len;
        end
        drain_results();
    endtask

    // receiver: random stall bursts plus long holds on request
    initial
    begin : out_pacer
        int burst_left;
        int hold_left;
        burst_left = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        ppcb_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (blur_expect_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected result word=%h row=%0d col=%0d last=%b", $realtime,
                             out_data.blurred_word, out_data.out_row, out_data.out_column,
                             out_data.last_of_frame);
            end
            else
            begin
                want = blur_expect_q.pop_front();
                if (out_data.blurred_word !== want.blurred_word ||
                    out_data.out_row !== want.out_row ||
                    out_data.out_column !== want.out_column ||
                    out_data.last_of_frame !== want.last_of_frame)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: mismatch exp word=%h row=%0d col=%0d last=%b, got word=%h row=%0d col=%0d last=%b",
                                 $realtime, want.blurred_word, want.out_row, want.out_column,
                                 want.last_of_frame, out_data.blurred_word, out_data.out_row,
                                 out_data.out_column, out_data.last_of_frame);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= REG_KEEP_AFTER_SHIFT;
        cfg_data  <= '0;
        keep_mask = KEEP_RESET;
        low_mask  = LOW_RESET;
        row_head  = '0;
        restart_position();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_patterns();
        test_mask_settings();
        test_early_restart();
        test_backpressure();
        test_random_frames();

        repeat (10) @(posedge clk);
        if (error_count == 0 && blur_expect_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
